FILE: src/u7e_pkg.sv
// Shared constants, types and character functions for the UTF-7 stream encoder.
`timescale 1ns / 1ps

package u7e_pkg;

    // Code unit width and derived sizes
    localparam int UNIT_BITS  = 16;
    localparam int PEND_W     = 5;
    localparam int PCNT_W     = 3;
    localparam int BUF_W      = PEND_W + UNIT_BITS;
    localparam int SCNT_W     = $clog2(BUF_W + 1);
    localparam int MAX_GROUPS = BUF_W / 6;
    localparam int MAX_OUT    = 4;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int IDX_W      = $clog2(MAX_OUT);
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    // Item kinds
    localparam logic KIND_UNIT = 1'b0;
    localparam logic KIND_EOM  = 1'b1;

    // Characters used as markers
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    // One queued run of output characters
    typedef struct packed {
        logic [MAX_OUT-1:0][6:0] chars;
        logic [CNT_W-1:0]        count;
    } run_t;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Base64 digit to ASCII
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] r;
        r = 7'd0;
        if (v < 6'd26)
            r = 7'h41 + {1'b0, v};
        else if (v < 6'd52)
            r = 7'h61 + {1'b0, v - 6'd26};
        else if (v < 6'd62)
            r = 7'h30 + {1'b0, v - 6'd52};
        else if (v == 6'd62)
            r = CH_PLUS;
        else
            r = 7'h2F;
        return r;
    endfunction

    // Base64 alphabet member
    function automatic logic is_b64(input logic [UNIT_BITS-1:0] c);
        return c inside {[16'h41:16'h5A], [16'h61:16'h7A], [16'h30:16'h39],
                         16'h2B, 16'h2F};
    endfunction

    // Sent directly in ASCII
    function automatic logic is_direct(input logic [UNIT_BITS-1:0] c);
        return is_b64(c) ||
               (c inside {16'h27, 16'h28, 16'h29, 16'h2C, 16'h2D, 16'h2E, 16'h3A,
                          16'h3F, 16'h20, 16'h09, 16'h0A, 16'h0D});
    endfunction

endpackage

FILE: src/utf7_stream_encoder.sv
// Top level of the UTF-7 stream encoder.
// Input channel (in_valid/in_ready): one transaction per item; kind 0 carries a
// 16-bit code unit to encode, kind 1 marks end of message and closes any open
// shift sequence.
// Output channel (out_valid/out_ready): one ASCII character per transaction;
// last_of_run is high on the final character caused by an input item.
// An item causes 1 to 4 characters; an end-of-message mark in direct mode
// causes none and leaves no trace on the output.
// The run of an accepted item is registered into the queue, and its first
// character is offered once that run is at the queue head. The front end builds
// a whole run in its accepting cycle and places it in a two-entry queue; the
// back end sends one character per cycle while out_ready is high, and the input
// keeps accepting while the queue has room.
// When the receiver stalls, the current character holds; once the queue is
// full, in_ready drops until the back end retires a run.
// Reset clears the queue and returns the encoder to direct mode with no
// leftover bits.
`timescale 1ns / 1ps

module utf7_stream_encoder
    import u7e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_char,
    output logic        last_of_run
);

    q_status_t q_status;
    run_t      push_run;
    run_t      head;
    logic      push;
    logic      pop;

    u7e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .code_unit (code_unit),
        .q_status  (q_status),
        .push      (push),
        .push_run  (push_run)
    );

    u7e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    u7e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

FILE: src/u7e_front.sv
// Front end: accepts items, tracks shift state and builds each run of characters.
`timescale 1ns / 1ps

module u7e_front
    import u7e_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [15:0]          code_unit,
    input  q_status_t            q_status,
    output logic                 push,
    output run_t                 push_run
);

    logic              shift_reg, shift_next;
    logic [PEND_W-1:0] bits_reg, bits_next;
    logic [PCNT_W-1:0] cnt_reg, cnt_next;

    logic [UNIT_BITS-1:0]    unit;
    logic [MAX_OUT-1:0][6:0] ch;
    logic [CNT_W-1:0]        n;
    logic [6:0]              flush_ch;
    logic                    has_flush;
    logic [10:0]             flush_tmp;
    logic [BUF_W-1:0]        sbuf;
    logic [SCNT_W-1:0]       scnt;
    logic                    accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign unit     = code_unit[UNIT_BITS-1:0];

    // Leftover bits padded with zeros on the right
    assign flush_tmp = 11'(bits_reg) << (3'd6 - cnt_reg);
    assign flush_ch  = b64_char(flush_tmp[5:0]);
    assign has_flush = (cnt_reg != '0);

    // Run builder and next state
    always_comb
    begin
        ch         = '0;
        n          = '0;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        sbuf       = '0;
        scnt       = '0;
        if (kind == KIND_EOM) begin
            if (shift_reg) begin
                if (has_flush) begin
                    ch[n[IDX_W-1:0]] = flush_ch;
                    n = n + 1'b1;
                end
                ch[n[IDX_W-1:0]] = CH_MINUS;
                n = n + 1'b1;
                shift_next = 1'b0;
                bits_next  = '0;
                cnt_next   = '0;
            end
        end
        else if (is_direct(unit)) begin
            if (shift_reg) begin
                if (has_flush) begin
                    ch[n[IDX_W-1:0]] = flush_ch;
                    n = n + 1'b1;
                end
                if (is_b64(unit) || unit == UNIT_BITS'(CH_MINUS)) begin
                    ch[n[IDX_W-1:0]] = CH_MINUS;
                    n = n + 1'b1;
                end
                shift_next = 1'b0;
                bits_next  = '0;
                cnt_next   = '0;
            end
            ch[n[IDX_W-1:0]] = unit[6:0];
            n = n + 1'b1;
            if (unit == UNIT_BITS'(CH_PLUS)) begin
                ch[n[IDX_W-1:0]] = CH_MINUS;
                n = n + 1'b1;
            end
        end
        else begin
            if (!shift_reg) begin
                ch[n[IDX_W-1:0]] = CH_PLUS;
                n = n + 1'b1;
                sbuf = {{PEND_W{1'b0}}, unit};
                scnt = SCNT_W'(UNIT_BITS);
            end
            else begin
                sbuf = {bits_reg, unit};
                scnt = SCNT_W'(cnt_reg) + SCNT_W'(UNIT_BITS);
            end
            // Six bits leave per base64 character
            for (int i = 0; i < MAX_GROUPS; i++) begin
                if (scnt >= SCNT_W'(6)) begin
                    scnt = scnt - SCNT_W'(6);
                    ch[n[IDX_W-1:0]] = b64_char(6'(sbuf >> scnt));
                    n = n + 1'b1;
                end
            end
            shift_next = 1'b1;
            cnt_next   = PCNT_W'(scnt);
            bits_next  = PEND_W'(sbuf & ~({BUF_W{1'b1}} << scnt));
        end
    end

    // Runs with no character are not queued
    assign push           = accept && (n != '0);
    assign push_run.chars = ch;
    assign push_run.count = n;

    // Shift state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shift_reg <= 1'b0;
            bits_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (accept) begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: src/u7e_queue.sv
// Two-entry queue of character runs between front and back.
`timescale 1ns / 1ps

module u7e_queue
    import u7e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_t      push_run,
    input  logic      pop,
    output run_t      head,
    output q_status_t q_status
);

    run_t              mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_run;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/u7e_back.sv
// Back end: sends the head run one character per transaction.
`timescale 1ns / 1ps

module u7e_back
    import u7e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       last_of_run
);

    logic [IDX_W-1:0] idx_reg;
    logic             fire;

    assign out_valid   = !q_status.empty;
    assign out_char    = head.chars[idx_reg];
    assign last_of_run = (CNT_W'(idx_reg) == head.count - 1'b1);
    assign fire        = out_valid && out_ready;
    assign pop         = fire && last_of_run;

    // Character index within the head run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (fire) begin
            if (last_of_run)
                idx_reg <= '0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

FILE: test/utf7_checker.sv
// Checker for the UTF-7 stream encoder: predicts each character and compares results.
`timescale 1ns / 1ps

module utf7_stream_checker
    import u7e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [15:0] code_unit,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  out_char,
    input  logic        last_of_run,
    output int          fail_count,
    output int          outstanding
);

    // One predicted output character
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } due_char_t;

    due_char_t  chars_due[$];
    logic [6:0] run_chars[$];

    // Encoder state as seen by the prediction
    logic       shift_open;
    logic [4:0] left_bits;
    logic [2:0] left_count;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        shift_open  = 1'b0;
        left_bits   = '0;
        left_count  = '0;
    end

    // Base64 digit to its ASCII letter
    function automatic logic [6:0] base64_digit(input logic [5:0] v);
        logic [7:0] code;
        if (v < 6'd26)
            code = "A" + 8'(v);
        else if (v < 6'd52)
            code = "a" + 8'(v - 6'd26);
        else if (v < 6'd62)
            code = "0" + 8'(v - 6'd52);
        else if (v == 6'd62)
            code = "+";
        else
            code = "/";
        return code[6:0];
    endfunction

    function automatic bit is_base64_unit(input logic [15:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "+" || c == "/";
    endfunction

    // Units that go out as plain ASCII
    function automatic bit is_plain_unit(input logic [15:0] c);
        if (c > 16'h007F)
            return 1'b0;
        if (is_base64_unit(c))
            return 1'b1;
        case (c[7:0])
            "'", "(", ")", ",", "-", ".", ":", "?", " ", "\t", "\n", "\r":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Leaving a shift: send leftover bits zero padded, back to direct mode
    task automatic close_shift();
        if (left_count != 3'd0)
            run_chars.push_back(base64_digit(6'({1'b0, left_bits} << (3'd6 - left_count))));
        left_bits  = '0;
        left_count = '0;
        shift_open = 1'b0;
    endtask

    // Work out the characters one accepted item causes
    task automatic encode_item(input logic k, input logic [15:0] cu);
        int unsigned unit;
        int unsigned acc;
        int unsigned cnt;
        unit = cu & ((1 << UNIT_BITS) - 1);
        run_chars.delete();
        if (k == KIND_EOM)
        begin
            if (shift_open)
            begin
                close_shift();
                run_chars.push_back(CH_MINUS);
            end
        end
        else if (is_plain_unit(16'(unit)))
        begin
            if (shift_open)
            begin
                close_shift();
                // a '-' keeps the next character from reading as base64
                if (is_base64_unit(16'(unit)) || unit == "-")
                    run_chars.push_back(CH_MINUS);
            end
            run_chars.push_back(7'(unit));
            if (unit == "+")
                run_chars.push_back(CH_MINUS);
        end
        else
        begin
            if (!shift_open)
            begin
                run_chars.push_back(CH_PLUS);
                shift_open = 1'b1;
                left_bits  = '0;
                left_count = '0;
            end
            acc = (int'(left_bits) << UNIT_BITS) | unit;
            cnt = left_count + UNIT_BITS;
            while (cnt >= 6)
            begin
                cnt -= 6;
                run_chars.push_back(base64_digit(6'(acc >> cnt)));
            end
            left_count = 3'(cnt);
            left_bits  = 5'(acc & ((1 << cnt) - 1));
        end
        foreach (run_chars[i])
            chars_due.push_back('{ch: run_chars[i], last: (i == run_chars.size() - 1)});
    endtask

    task automatic report(input string what, input int want, input int got);
        $display("%0t ns: mismatch, %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        fail_count++;
    endtask

    // Compare output transactions first, then predict from input transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (chars_due.size() == 0)
                    report("character with none pending", 0, out_char);
                else
                begin
                    due_char_t want;
                    want = chars_due.pop_front();
                    if (out_char !== want.ch)
                        report("out_char", want.ch, out_char);
                    if (last_of_run !== want.last)
                        report("last_of_run", want.last, last_of_run);
                end
            end
            if (in_valid && in_ready)
                encode_item(kind, code_unit);
            outstanding = chars_due.size();
        end
    end

endmodule

FILE: test/testbench.sv
// Top of the UTF-7 stream encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench
    import u7e_pkg::*;
();

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int RX_HOLD_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [15:0] code_unit;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  out_char;
    logic        last_of_run;

    int fail_count;
    int outstanding;
    int cycles;

    // Shared between stimulus and receiver
    bit no_idle;
    bit rx_hold_req;

    utf7_stream_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .code_unit   (code_unit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    utf7_stream_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .code_unit   (code_unit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 20 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run guard
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** utf7_stream_encoder: FAILED **");
            $finish;
        end
    end

    // Receiver: random wait per character, plus one long hold on request
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready   = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!(out_valid || rx_hold_req));
        end
    end

    // Offer one item after a random gap; return at the falling edge after acceptance
    task automatic send_item(input logic k, input logic [15:0] cu);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = k;
        code_unit = cu;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [7:0] punct_char(input int idx);
        case (idx)
            0:       return "'";
            1:       return "(";
            2:       return ")";
            3:       return ",";
            4:       return ".";
            5:       return ":";
            6:       return "?";
            7:       return " ";
            8:       return "\t";
            9:       return "\n";
            10:      return "\r";
            11:      return "/";
            12:      return "+";
            default: return "-";
        endcase
    endfunction

    // Random item: mostly text mixed with runs of wide units
    task automatic pick_random(output logic k, output logic [15:0] cu);
        int sel;
        sel = $urandom_range(0, 99);
        k   = KIND_UNIT;
        cu  = 16'($urandom);
        if (sel < 8)
            k = KIND_EOM;
        else if (sel < 30)
        begin
            case ($urandom_range(0, 2))
                0:       cu = "A" + 16'($urandom_range(0, 25));
                1:       cu = "a" + 16'($urandom_range(0, 25));
                default: cu = "0" + 16'($urandom_range(0, 9));
            endcase
        end
        else if (sel < 45)
            cu = 16'(punct_char($urandom_range(0, 14)));
        else if (sel < 58)
            cu = 16'($urandom_range(0, 127));
    endtask

    initial
    begin : stimulus
        logic        k;
        logic [15:0] cu;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_UNIT;
        code_unit   = '0;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: plain text, shifts at every leftover count, closings
        send_item(KIND_UNIT, "A");
        send_item(KIND_UNIT, "+");
        send_item(KIND_UNIT, " ");
        send_item(KIND_UNIT, "\t");
        send_item(KIND_UNIT, "?");
        send_item(KIND_UNIT, 16'h0000);
        send_item(KIND_UNIT, 16'hFFFF);
        send_item(KIND_UNIT, 16'h2222);     // no leftover bits after this one
        send_item(KIND_UNIT, "a");          // close with '-' before a letter
        send_item(KIND_UNIT, 16'h00E9);
        send_item(KIND_UNIT, ".");          // close without '-'
        send_item(KIND_UNIT, 16'h007F);
        send_item(KIND_UNIT, "-");          // close with '-' before '-'
        send_item(KIND_UNIT, 16'h8000);
        send_item(KIND_EOM, 16'hFFFF);      // end of message inside a shift
        send_item(KIND_EOM, 16'h0000);      // end of message in direct mode
        send_item(KIND_UNIT, 16'h007E);
        send_item(KIND_UNIT, 16'h1234);
        send_item(KIND_UNIT, 16'h5678);
        send_item(KIND_UNIT, "+");          // three characters from one item
        send_item(KIND_UNIT, 16'hABCD);
        send_item(KIND_UNIT, "\n");
        send_item(KIND_UNIT, "\r");
        send_item(KIND_UNIT, "/");
        send_item(KIND_UNIT, 16'h4141);
        send_item(KIND_EOM, 16'h5A5A);

        // Back pressure: receiver stalls while the sender keeps offering
        rx_hold_req = 1'b1;
        no_idle     = 1'b1;
        repeat (20) send_item(KIND_UNIT, 16'($urandom_range(16'h0100, 16'hFFFF)));
        no_idle = 1'b0;

        // Sender pause until everything has drained
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);

        // Random traffic with a stretch of no idling on either side
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 150 && i < 220);
            pick_random(k, cu);
            send_item(k, cu);
        end
        no_idle  = 1'b0;
        in_valid = 1'b0;

        // Drain, then leave time for anything stray
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("** utf7_stream_encoder: PASSED **");
        else
            $display("** utf7_stream_encoder: FAILED **");
        $finish;
    end

endmodule
